// ===== sv/ppte_pkg.sv =====
// shared types, constants and saturation helper for the trajectory evaluator
package ppte_pkg;

  localparam int CoefW  = 48;
  localparam int TimeW  = 32;
  localparam int DurW   = 32;
  localparam int AccW   = 40;   // holds the sum of up to 256 durations
  localparam int IdxW   = 8;    // segment index at the largest table size
  localparam int SegW   = 4;
  localparam int CselW  = 3;
  localparam int OpW    = 2;
  localparam int CntW   = 5;
  localparam int NW     = 9;    // clamped segment count, up to 256
  localparam int SatInW = 82;

  localparam logic [OpW-1:0] OpWrCoef = 2'd0;
  localparam logic [OpW-1:0] OpWrDur  = 2'd1;
  localparam logic [OpW-1:0] OpQuery  = 2'd2;

  localparam logic signed [CoefW-1:0] PosMax = {1'b0, {(CoefW-1){1'b1}}};
  localparam logic signed [CoefW-1:0] NegMax = {1'b1, {(CoefW-1){1'b0}}};

  typedef struct packed {
    logic                    vld;
    logic [OpW-1:0]          op;
    logic [SegW-1:0]         seg;
    logic [CselW-1:0]        cs;
    logic signed [CoefW-1:0] coef;
    logic [DurW-1:0]         dur;
    logic signed [TimeW-1:0] t;
    logic                    query;
    logic                    zero;
    logic                    found;
    logic [IdxW-1:0]         idx;
    logic [AccW-1:0]         acc;
    logic [AccW-1:0]         start;
  } srch_t;

  typedef struct packed {
    logic                    vld;
    logic [OpW-1:0]          op;
    logic [SegW-1:0]         seg;
    logic [CselW-1:0]        cs;
    logic signed [CoefW-1:0] coef;
    logic                    query;
    logic                    zero;
    logic [IdxW-1:0]         idx;
    logic signed [TimeW-1:0] tl;
    logic signed [CoefW-1:0] pos;
    logic signed [CoefW-1:0] vel;
    logic                    sat;
  } hrn_t;

  typedef struct packed {
    logic                    clip;
    logic signed [CoefW-1:0] val;
  } sat_t;

  function automatic sat_t sat48(input logic signed [SatInW-1:0] v);
    sat_t r;
    r.clip = 1'b0;
    r.val  = v[CoefW-1:0];
    if (v > SatInW'(PosMax)) begin
      r.clip = 1'b1;
      r.val  = PosMax;
    end else if (v < SatInW'(NegMax)) begin
      r.clip = 1'b1;
      r.val  = NegMax;
    end
    return r;
  endfunction

endpackage

// ===== sv/ppte_seg_stage.sv =====
// one segment search stage: holds one duration and tests one cumulative end time
module ppte_seg_stage #(
  parameter int unsigned Idx
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic [ppte_pkg::NW-1:0] n_i,
  input  ppte_pkg::srch_t      in_i,
  output ppte_pkg::srch_t      out_o
);
  import ppte_pkg::*;

  logic [DurW-1:0]        dur_q;
  srch_t                  stage_d, stage_q;
  logic [AccW-1:0]        end_w;
  logic signed [AccW:0]   t_ext;
  logic                   active, last, hit;

  always_comb begin
    end_w   = in_i.acc + AccW'(dur_q);
    t_ext   = (AccW+1)'(in_i.t);
    hit     = t_ext <= $signed({1'b0, end_w});
    active  = in_i.query && !in_i.found && (NW'(Idx) < n_i);
    last    = NW'(Idx) == (n_i - 1'b1);
    stage_d = in_i;
    if (active) begin
      if (hit || last) begin
        stage_d.found = 1'b1;
        stage_d.idx   = IdxW'(Idx);
        stage_d.start = in_i.acc;
      end else begin
        stage_d.acc = end_w;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && in_i.vld && in_i.op == OpWrDur && IdxW'(in_i.seg) == IdxW'(Idx)) begin
      dur_q <= in_i.dur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q.vld <= 1'b0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign out_o = stage_q;

endmodule

// ===== sv/ppte_horner_step.sv =====
// one horner step for position and velocity with its coefficient column
module ppte_horner_step #(
  parameter int unsigned K,
  parameter int unsigned MaxSeg,
  parameter int unsigned Frac
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  ppte_pkg::hrn_t  in_i,
  output ppte_pkg::hrn_t  out_o
);
  import ppte_pkg::*;

  localparam int IW = (MaxSeg > 1) ? $clog2(MaxSeg) : 1;
  localparam int HalfW = 24;

  logic signed [CoefW-1:0] mem [MaxSeg];
  logic signed [CoefW-1:0] rd_q, crd_q;
  logic signed [50:0]      kc_d, kc_q;
  logic signed [55:0]      pph_d, pph_q, vph_d, vph_q;
  logic signed [56:0]      ppl_d, ppl_q, vpl_d, vpl_q;
  logic signed [SatInW-1:0] pfull, vfull;
  sat_t                    pr, vr, pa, va;
  hrn_t                    b_q, c_d, c_q, o_d, o_q;
  logic                    wr;

  assign wr = in_i.vld && in_i.op == OpWrCoef && in_i.cs == CselW'(K)
              && NW'(in_i.seg) < NW'(MaxSeg);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (wr) begin
        mem[IW'(in_i.seg)] <= in_i.coef;
      end
      rd_q <= mem[in_i.idx[IW-1:0]];
    end
  end

  // split each accumulator into a signed high and an unsigned low part
  always_comb begin
    pph_d = $signed(in_i.pos[CoefW-1:HalfW]) * in_i.tl;
    ppl_d = $signed({1'b0, in_i.pos[HalfW-1:0]}) * in_i.tl;
    vph_d = $signed(in_i.vel[CoefW-1:HalfW]) * in_i.tl;
    vpl_d = $signed({1'b0, in_i.vel[HalfW-1:0]}) * in_i.tl;
  end

  always_comb begin
    pfull = ((SatInW'(pph_q) <<< HalfW) + SatInW'(ppl_q)
             + (SatInW'(1) <<< (Frac - 1))) >>> Frac;
    vfull = ((SatInW'(vph_q) <<< HalfW) + SatInW'(vpl_q)
             + (SatInW'(1) <<< (Frac - 1))) >>> Frac;
    pr    = sat48(pfull);
    vr    = sat48(vfull);
    kc_d  = 51'(rd_q) * 51'(K);
    c_d     = b_q;
    c_d.pos = pr.val;
    c_d.sat = b_q.sat | pr.clip;
    if (K >= 1) begin
      c_d.vel = vr.val;
      c_d.sat = b_q.sat | pr.clip | vr.clip;
    end
  end

  always_comb begin
    pa      = sat48(SatInW'(c_q.pos) + SatInW'(crd_q));
    va      = sat48(SatInW'(c_q.vel) + SatInW'(kc_q));
    o_d     = c_q;
    o_d.pos = pa.val;
    o_d.sat = c_q.sat | pa.clip;
    if (K >= 1) begin
      o_d.vel = va.val;
      o_d.sat = c_q.sat | pa.clip | va.clip;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pph_q <= pph_d;
      ppl_q <= ppl_d;
      vph_q <= vph_d;
      vpl_q <= vpl_d;
      crd_q <= rd_q;
      kc_q  <= kc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q.vld <= 1'b0;
      c_q.vld <= 1'b0;
      o_q.vld <= 1'b0;
    end else if (en_i) begin
      b_q <= in_i;
      c_q <= c_d;
      o_q <= o_d;
    end
  end

  assign out_o = o_q;

endmodule

// ===== sv/piecewise_poly_trajectory_eval.sv =====
// top level: segment search pipeline followed by seven horner steps
//
//  channel  valid        stall        payload
//  input    in_valid_i   in_stall_o   operation_i .. query_time_i
//  output   out_valid_o  out_stall_i  position_o, velocity_o, found_segment_o, saturated_o
//  config   cfg_we_i     -            cfg_data_i (segment_count)
//
// an item enters every cycle unless an output stall holds the pipeline; a query passes
// one search stage per segment, two stages for the top coefficient
// and three stages per horner step (partial products, round, add)
// writes travel the same pipeline and update the tables at the stage that reads them
// an output stall freezes the whole pipeline; reset clears valid bits and segment_count
module piecewise_poly_trajectory_eval #(
  parameter int unsigned MAX_SEGMENTS   = 16,
  parameter int unsigned TIME_FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [ppte_pkg::OpW-1:0]        operation_i,
  input  logic [ppte_pkg::SegW-1:0]       segment_select_i,
  input  logic [ppte_pkg::CselW-1:0]      coefficient_select_i,
  input  logic signed [ppte_pkg::CoefW-1:0] coefficient_value_i,
  input  logic [ppte_pkg::DurW-1:0]       duration_value_i,
  input  logic signed [ppte_pkg::TimeW-1:0] query_time_i,
  input  logic                            cfg_we_i,
  input  logic [ppte_pkg::CntW-1:0]       cfg_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [ppte_pkg::CoefW-1:0] position_o,
  output logic signed [ppte_pkg::CoefW-1:0] velocity_o,
  output logic [ppte_pkg::SegW-1:0]       found_segment_o,
  output logic                            saturated_o
);
  import ppte_pkg::*;

  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  logic [CntW-1:0]         cnt_q;
  logic [NW-1:0]           n_w;
  logic                    en;
  srch_t                   sch [MAX_SEGMENTS+1];
  hrn_t                    hch [8];
  hrn_t                    i1_d, i1_q, i2_d, i2_q;
  logic signed [CoefW-1:0] mem7 [MAX_SEGMENTS];
  logic signed [CoefW-1:0] rd7_q;
  logic signed [SatInW-1:0] r7x;
  logic signed [AccW:0]    tl_w;
  sat_t                    v7;
  hrn_t                    last;

  assign n_w = (NW'(cnt_q) > NW'(MAX_SEGMENTS)) ? NW'(MAX_SEGMENTS) : NW'(cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cfg_we_i) begin
      cnt_q <= cfg_data_i;
    end
  end

  assign last        = hch[0];
  assign out_valid_o = last.vld && last.query;
  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;

  always_comb begin
    sch[0].vld   = in_valid_i;
    sch[0].op    = operation_i;
    sch[0].seg   = segment_select_i;
    sch[0].cs    = coefficient_select_i;
    sch[0].coef  = coefficient_value_i;
    sch[0].dur   = duration_value_i;
    sch[0].t     = query_time_i;
    sch[0].query = operation_i == OpQuery;
    sch[0].zero  = n_w == '0;
    sch[0].found = 1'b0;
    sch[0].idx   = '0;
    sch[0].acc   = '0;
    sch[0].start = '0;
  end

  for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_seg
    ppte_seg_stage #(.Idx(g)) u_seg (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .n_i   (n_w),
      .in_i  (sch[g]),
      .out_o (sch[g+1])
    );
  end

  // local time and the read of the top coefficient
  always_comb begin
    tl_w       = (AccW+1)'(sch[MAX_SEGMENTS].t) - $signed({1'b0, sch[MAX_SEGMENTS].start});
    i1_d.vld   = sch[MAX_SEGMENTS].vld;
    i1_d.op    = sch[MAX_SEGMENTS].op;
    i1_d.seg   = sch[MAX_SEGMENTS].seg;
    i1_d.cs    = sch[MAX_SEGMENTS].cs;
    i1_d.coef  = sch[MAX_SEGMENTS].coef;
    i1_d.query = sch[MAX_SEGMENTS].query;
    i1_d.zero  = sch[MAX_SEGMENTS].zero;
    i1_d.idx   = sch[MAX_SEGMENTS].idx;
    i1_d.tl    = tl_w[TimeW-1:0];
    i1_d.pos   = '0;
    i1_d.vel   = '0;
    i1_d.sat   = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (i1_d.vld && i1_d.op == OpWrCoef && i1_d.cs == CselW'(7)
          && NW'(i1_d.seg) < NW'(MAX_SEGMENTS)) begin
        mem7[IW'(i1_d.seg)] <= i1_d.coef;
      end
      rd7_q <= mem7[i1_d.idx[IW-1:0]];
    end
  end

  always_comb begin
    r7x      = SatInW'(rd7_q);
    v7       = sat48((r7x <<< 3) - r7x);
    i2_d     = i1_q;
    i2_d.pos = rd7_q;
    i2_d.vel = v7.val;
    i2_d.sat = v7.clip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i1_q.vld <= 1'b0;
      i2_q.vld <= 1'b0;
    end else if (en) begin
      i1_q <= i1_d;
      i2_q <= i2_d;
    end
  end

  assign hch[7] = i2_q;

  for (genvar k = 0; k < 7; k++) begin : g_step
    ppte_horner_step #(.K(k), .MaxSeg(MAX_SEGMENTS), .Frac(TIME_FRAC_BITS)) u_step (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .in_i  (hch[k+1]),
      .out_o (hch[k])
    );
  end

  // zero segments in use give an all-zero result
  assign position_o      = last.zero ? '0 : last.pos;
  assign velocity_o      = last.zero ? '0 : last.vel;
  assign found_segment_o = last.zero ? '0 : last.idx[SegW-1:0];
  assign saturated_o     = last.zero ? 1'b0 : last.sat;

endmodule
